// ----- src/sky_texcoord_fan_emitter_unit_defines.svh -----
// Assertion macros for the sky texcoord fan emitter.
// Taken in by the files that carry assertions; no other dependencies.
`ifndef SKY_TEXCOORD_FAN_EMITTER_UNIT_DEFINES_SVH
`define SKY_TEXCOORD_FAN_EMITTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define STFE_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("stfe: same-cycle check failed");
`define STFE_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("stfe: next-cycle check failed");
`else
`define STFE_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define STFE_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ----- src/stfe_pkg.sv -----
// Shared types and constants for the sky texcoord fan emitter.
// No dependencies.
package stfe_pkg;

	localparam int SQ_W    = 44;	// sum of squares
	localparam int LEN_W   = 30;	// distance in 1/256 units
	localparam int NUM_W   = 47;	// divider numerator
	localparam int QUO_W   = 20;	// divider quotient
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// 378 * 512 * 256
	localparam logic [25:0] RADIUS_SCALE = 26'd49545216;

	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EYE_X  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z  = 2'd3;

	typedef struct packed {
		logic signed [19:0] pos_x;
		logic signed [19:0] pos_y;
		logic signed [19:0] pos_z;
		logic               starts_polygon;
	} in_item_t;

	typedef struct packed {
		logic signed [19:0] out_x;
		logic signed [19:0] out_y;
		logic signed [19:0] out_z;
		logic signed [19:0] tex_s;
		logic signed [19:0] tex_t;
		logic               last_of_triangle;
	} out_item_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic signed [19:0] s;
		logic signed [19:0] t;
	} vtx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_status_t;

endpackage

// ----- src/stfe_root.sv -----
// Bit-serial integer square root of (radicand << 16), one result bit a cycle.
// Depends on stfe_pkg.
module stfe_root (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [stfe_pkg::SQ_W-1:0]  radicand,
	output stfe_pkg::ser_status_t      status,
	output logic [stfe_pkg::LEN_W-1:0] root
);
	localparam int X_W   = 2 * stfe_pkg::LEN_W;
	localparam int REM_W = stfe_pkg::LEN_W + 3;
	localparam int CNT_W = $clog2(stfe_pkg::LEN_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(stfe_pkg::LEN_W - 1);

	logic [X_W-1:0]                x_q;
	logic [REM_W-1:0]              rem_q;
	logic [stfe_pkg::LEN_W-1:0]    root_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q, done_q;
	logic [REM_W-1:0]              rem_n, trial;
	logic                          ge;

	assign rem_n = {rem_q[REM_W-3:0], x_q[X_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= {radicand, (X_W - stfe_pkg::SQ_W)'(0)};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[X_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_q[stfe_pkg::LEN_W-2:0], ge};
		end
	end

	assign status = '{busy: busy_q, done: done_q};
	assign root   = root_q;
endmodule

// ----- src/stfe_div.sv -----
// Restoring divider, one quotient bit a cycle; the quotient is known to fit QUO_W bits.
// Depends on stfe_pkg.
module stfe_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [stfe_pkg::NUM_W-1:0] num,
	input  logic [stfe_pkg::LEN_W-1:0] den,
	output stfe_pkg::ser_status_t      status,
	output logic [stfe_pkg::QUO_W-1:0] quo
);
	localparam int QW    = stfe_pkg::QUO_W;
	localparam int DW    = stfe_pkg::LEN_W;
	localparam int CNT_W = $clog2(QW);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

	logic [DW-1:0]    rem_q, den_q;
	logic [QW-1:0]    shf_q, quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DW:0]      rem_n, diff;
	logic             ge;

	assign rem_n = {rem_q, shf_q[QW-1]};
	assign diff  = rem_n - {1'b0, den_q};
	assign ge    = rem_n >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high part of the numerator is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(num[stfe_pkg::NUM_W-1:QW]);
			shf_q <= num[QW-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_n[DW-1:0];
			shf_q <= {shf_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign status = '{busy: busy_q, done: done_q};
	assign quo    = quo_q;
endmodule

// ----- src/sky_texcoord_fan_emitter_unit.sv -----
// Sky texcoord fan emitter: scrolling sky texture coordinates and fan-to-triangle output.
// Depends on stfe_pkg, stfe_root, stfe_div and the assertion macro header.
//
//  channel  signals                      transfer when
//  in       in_valid/in_stall/in_data    in_valid && !in_stall
//  out      out_valid/out_stall/out_data out_valid && !out_stall
//  cfg      cfg_we/cfg_index/cfg_data    cfg_we
//
// A vertex is taken in, then passes the sum of squares, the serial square root and two
// divides with a multiply step before each, a finish step and the emission of the three
// vertices of its triangle; the next vertex is taken only once the sequencer is back in
// idle. The root and the single shared divider take most of that time. Zero distance skips
// both. The first and second vertex of a polygon emit nothing.
// Reset clears the sequencer, polygon state and configuration registers. An output stall holds
// emission; the next vertex may enter while the last result still waits.
`include "sky_texcoord_fan_emitter_unit_defines.svh"
module sky_texcoord_fan_emitter_unit #(
	parameter int MAX_POLY_VERTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  stfe_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output stfe_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [stfe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int CNT_W = $clog2(MAX_POLY_VERTS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POLY_VERTS);
	localparam logic signed [19:0] SMAX = 20'sh7FFFF;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQR  = 9'b000000010,
		ST_ROOT = 9'b000000100,
		ST_MULS = 9'b000001000,
		ST_DIVS = 9'b000010000,
		ST_MULT = 9'b000100000,
		ST_DIVT = 9'b001000000,
		ST_FIN  = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

	state_t                      state_q;
	logic [14:0]                 scroll_q;
	logic signed [19:0]          eye_x_q, eye_y_q, eye_z_q;
	logic signed [20:0]          dx_q, dy_q;
	logic signed [22:0]          dz3_q;
	logic [stfe_pkg::SQ_W-1:0]   acc_q;
	logic [1:0]                  sq_cnt_q;
	logic [stfe_pkg::LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]            count_q;
	logic [1:0]                  emit_idx_q;
	stfe_pkg::vtx_t              cur_q, first_q, prev_q;
	logic                        out_valid_q;
	stfe_pkg::out_item_t         out_q;

	// accept path
	logic                        in_xfer, drop;
	logic [CNT_W-1:0]            eff_cnt;
	logic signed [20:0]          dz_n;
	logic signed [22:0]          dz_ext;

	// square path
	logic signed [22:0]          sq_op;
	logic [21:0]                 sq_mag;
	logic [43:0]                 sq;

	// divide path
	stfe_pkg::ser_status_t       root_st, div_st;
	logic [stfe_pkg::LEN_W-1:0]  root_val;
	logic [stfe_pkg::QUO_W-1:0]  div_quo;
	logic                        div_start;
	logic signed [20:0]          d_sel;
	logic [20:0]                 d_mag;
	logic [stfe_pkg::NUM_W-1:0]  num;
	logic                        out_free;
	logic                        emit_go;

	function automatic logic signed [19:0] tex_term(input logic [14:0] scr,
		input logic neg, input logic [stfe_pkg::QUO_W-1:0] q);
		logic signed [21:0] qz, term, sum;
		qz   = $signed({2'b00, q});
		term = neg ? -qz : qz;
		sum  = $signed({6'b0, scr, 1'b0}) + term;
		if (sum > 22'sd524287)
			return 20'sh7FFFF;
		else if (sum < -22'sd524288)
			return -20'sh80000;
		return sum[19:0];
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign eff_cnt  = in_data.starts_polygon ? '0 : count_q;
	assign drop     = (eff_cnt >= MAX_CNT);
	assign dz_n     = $signed({in_data.pos_z[19], in_data.pos_z}) - $signed({eye_z_q[19], eye_z_q});
	assign dz_ext   = {{2{dz_n[20]}}, dz_n};

	always_comb begin
		case (sq_cnt_q)
			2'd0:    sq_op = {{2{dx_q[20]}}, dx_q};
			2'd1:    sq_op = {{2{dy_q[20]}}, dy_q};
			2'd2:    sq_op = dz3_q;
			default: sq_op = '0;
		endcase
	end
	assign sq_mag = sq_op[22] ? 22'(-sq_op) : 22'(sq_op);
	assign sq     = sq_mag * sq_mag;

	assign d_sel     = (state_q == ST_MULT) ? dy_q : dx_q;
	assign d_mag     = d_sel[20] ? 21'(-d_sel) : 21'(d_sel);
	assign num       = stfe_pkg::NUM_W'(d_mag) * stfe_pkg::NUM_W'(stfe_pkg::RADIUS_SCALE)
	                 + stfe_pkg::NUM_W'(len_q >> 1);
	assign div_start = (state_q == ST_MULS) || (state_q == ST_MULT);
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_go   = (state_q == ST_EMIT) && out_free;

	stfe_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_SQR) && (sq_cnt_q == 2'd3) && (acc_q != '0)),
		.radicand (acc_q),
		.status   (root_st),
		.root     (root_val)
	);

	stfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (len_q),
		.status (div_st),
		.quo    (div_quo)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q <= '0;
			eye_x_q  <= '0;
			eye_y_q  <= '0;
			eye_z_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stfe_pkg::CFG_SCROLL: scroll_q <= cfg_data[14:0];
				stfe_pkg::CFG_EYE_X:  eye_x_q  <= cfg_data[19:0];
				stfe_pkg::CFG_EYE_Y:  eye_y_q  <= cfg_data[19:0];
				stfe_pkg::CFG_EYE_Z:  eye_z_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// sequencer and polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sq_cnt_q    <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			first_q     <= '0;
			prev_q      <= '0;
		end else begin
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && !drop) begin
						count_q  <= eff_cnt;
						sq_cnt_q <= '0;
						state_q  <= ST_SQR;
					end
				end
				ST_SQR: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 2'd3)
						state_q <= (acc_q == '0) ? ST_FIN : ST_ROOT;
				end
				ST_ROOT: if (root_st.done) state_q <= ST_MULS;
				ST_MULS: state_q <= ST_DIVS;
				ST_DIVS: if (div_st.done) state_q <= ST_MULT;
				ST_MULT: state_q <= ST_DIVT;
				ST_DIVT: if (div_st.done) state_q <= ST_FIN;
				ST_FIN: begin
					if (count_q == '0) begin
						first_q <= cur_q;
						count_q <= CNT_W'(1);
						state_q <= ST_IDLE;
					end else if (count_q == CNT_W'(1)) begin
						prev_q  <= cur_q;
						count_q <= CNT_W'(2);
						state_q <= ST_IDLE;
					end else begin
						emit_idx_q <= '0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						emit_idx_q <= emit_idx_q + 1'b1;
						if (emit_idx_q == 2'd2) begin
							prev_q  <= cur_q;
							count_q <= count_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q.x <= in_data.pos_x;
			cur_q.y <= in_data.pos_y;
			cur_q.z <= in_data.pos_z;
			dx_q    <= $signed({in_data.pos_x[19], in_data.pos_x})
			         - $signed({eye_x_q[19], eye_x_q});
			dy_q    <= $signed({in_data.pos_y[19], in_data.pos_y})
			         - $signed({eye_y_q[19], eye_y_q});
			dz3_q   <= dz_ext + (dz_ext <<< 1);
			acc_q   <= '0;
		end
		if (state_q == ST_SQR && sq_cnt_q != 2'd3)
			acc_q <= acc_q + sq;
		if (state_q == ST_SQR && sq_cnt_q == 2'd3 && acc_q == '0) begin
			cur_q.s <= SMAX;
			cur_q.t <= SMAX;
		end
		if (state_q == ST_ROOT && root_st.done)
			len_q <= root_val;
		if (state_q == ST_DIVS && div_st.done)
			cur_q.s <= tex_term(scroll_q, dx_q[20], div_quo);
		if (state_q == ST_DIVT && div_st.done)
			cur_q.t <= tex_term(scroll_q, dy_q[20], div_quo);
		if (emit_go) begin
			case (emit_idx_q)
				2'd0:    out_q <= '{first_q.x, first_q.y, first_q.z, first_q.s, first_q.t, 1'b0};
				2'd1:    out_q <= '{prev_q.x, prev_q.y, prev_q.z, prev_q.s, prev_q.t, 1'b0};
				default: out_q <= '{cur_q.x, cur_q.y, cur_q.z, cur_q.s, cur_q.t, 1'b1};
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`STFE_ASSERT_NXT(a_root_then_mul, clk, arst_n, root_st.done, state_q == ST_MULS)
	`STFE_ASSERT_IMP(a_div_in_div_state, clk, arst_n, div_st.done, (state_q == ST_DIVS) || (state_q == ST_DIVT))
	`STFE_ASSERT_IMP(a_emit_needs_two, clk, arst_n, state_q == ST_EMIT, count_q >= CNT_W'(2))
	`STFE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_CNT)
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for sky_texcoord_fan_emitter_unit: directed table, then random polygons.
// Depends on stfe_pkg and the emitter RTL; holds its own texcoord and fan predictor.
`timescale 1ns / 100ps
module testbench;

	localparam int MAX_VERTS   = 256;
	localparam int SETTLE_CYC  = 200;
	localparam int CYCLE_LIMIT = 150000;
	localparam logic signed [19:0] P_MAX = 20'sd524287;
	localparam logic signed [19:0] P_MIN = -20'sd524288;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	stfe_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	stfe_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [stfe_pkg::CFG_IDX_W-1:0] cfg_index = stfe_pkg::CFG_SCROLL;
	logic [stfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the polygon state
	logic [31:0] scroll_reg;
	logic signed [19:0] eye_x, eye_y, eye_z;
	stfe_pkg::vtx_t fan_first, fan_prev;
	int fan_count;
	stfe_pkg::out_item_t tri_q[$];
	int fails = 0;
	int cycles = 0;
	int tx_pct = 0, rx_pct = 0;

	typedef struct {
		logic signed [19:0] x, y, z;
		logic               start;
		logic               known;	// expects zero distance saturation of the texcoords
	} row_t;

	sky_texcoord_fan_emitter_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_pct);
	end

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// horizontal offset scaled to the sky radius, rounded half away from zero
	function automatic longint radius_term(longint d, longint unsigned len);
		longint unsigned mag, q;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		q = (mag * (378 * 512 * 256) + len / 2) / len;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [19:0] clamp20(longint v);
		if (v > 524287)
			return P_MAX;
		if (v < -524288)
			return P_MIN;
		return v[19:0];
	endfunction

	function automatic stfe_pkg::vtx_t sky_vertex(stfe_pkg::in_item_t it);
		stfe_pkg::vtx_t v;
		longint dx, dy, dz3, sc;
		longint unsigned dd, len;
		v.x = it.pos_x;
		v.y = it.pos_y;
		v.z = it.pos_z;
		dx = longint'(it.pos_x) - longint'(eye_x);
		dy = longint'(it.pos_y) - longint'(eye_y);
		dz3 = 3 * (longint'(it.pos_z) - longint'(eye_z));
		dd = dx * dx + dy * dy + dz3 * dz3;
		if (dd == 0) begin
			v.s = P_MAX;
			v.t = P_MAX;
		end else begin
			len = int_root(dd << 16);
			sc = longint'(scroll_reg[14:0]) * 2;
			v.s = clamp20(sc + radius_term(dx, len));
			v.t = clamp20(sc + radius_term(dy, len));
		end
		return v;
	endfunction

	function automatic stfe_pkg::out_item_t as_result(stfe_pkg::vtx_t v, logic last);
		return '{out_x: v.x, out_y: v.y, out_z: v.z, tex_s: v.s, tex_t: v.t,
			last_of_triangle: last};
	endfunction

	// accepted vertex: advance the fan and queue any triangle it closes
	task automatic fan_step(stfe_pkg::in_item_t it);
		stfe_pkg::vtx_t cur;
		if (it.starts_polygon)
			fan_count = 0;
		if (fan_count >= MAX_VERTS)
			return;
		cur = sky_vertex(it);
		if (fan_count == 0) begin
			fan_first = cur;
			fan_count = 1;
		end else if (fan_count == 1) begin
			fan_prev = cur;
			fan_count = 2;
		end else begin
			tri_q.push_back(as_result(fan_first, 1'b0));
			tri_q.push_back(as_result(fan_prev, 1'b0));
			tri_q.push_back(as_result(cur, 1'b1));
			fan_prev = cur;
			fan_count++;
		end
	endtask

	task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		stfe_pkg::out_item_t want;
		if (arst_n && in_valid && !in_stall)
			fan_step(in_data);
		if (arst_n && out_valid && !out_stall) begin
			if (tri_q.size() == 0) begin
				$display("%0t: expected no transfer got %h", $time, out_data);
				fails++;
			end else begin
				want = tri_q.pop_front();
				check_field("out_x", want.out_x, out_data.out_x);
				check_field("out_y", want.out_y, out_data.out_y);
				check_field("out_z", want.out_z, out_data.out_z);
				check_field("tex_s", want.tex_s, out_data.tex_s);
				check_field("tex_t", want.tex_t, out_data.tex_t);
				check_field("last_of_triangle", 20'(want.last_of_triangle),
					20'(out_data.last_of_triangle));
			end
		end
	end

	task automatic send_vertex(stfe_pkg::in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (tri_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write enable is left high; the caller drops it after the last write
	task automatic write_reg(logic [stfe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			stfe_pkg::CFG_SCROLL: scroll_reg = val;
			stfe_pkg::CFG_EYE_X:  eye_x = val[19:0];
			stfe_pkg::CFG_EYE_Y:  eye_y = val[19:0];
			stfe_pkg::CFG_EYE_Z:  eye_z = val[19:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [19:0] pick_coord(logic signed [19:0] eye_c);
		case ($urandom_range(3))
			0: return eye_c + 20'($urandom_range(64)) - 20'sd32;
			1: return $urandom_range(1) ? P_MAX : P_MIN;
			default: return 20'($urandom);
		endcase
	endfunction

	row_t dir_rows[] = '{
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},	// no start mark after reset
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},
		'{P_MAX, P_MAX, P_MAX, 1'b1, 1'b0},
		'{P_MIN, P_MIN, P_MIN, 1'b0, 1'b0},
		'{P_MAX, P_MIN, 20'sd0, 1'b0, 1'b0},
		'{P_MIN, P_MAX, P_MAX, 1'b0, 1'b0},
		'{20'sd1, 20'sd0, 20'sd0, 1'b0, 1'b0},
		'{20'sd0, -20'sd1, 20'sd0, 1'b0, 1'b0},
		'{20'sd0, 20'sd0, 20'sd1, 1'b0, 1'b0},
		'{-20'sd1, -20'sd1, -20'sd1, 1'b0, 1'b0},
		'{20'sd16, 20'sd0, 20'sd0, 1'b1, 1'b0},
		'{20'sd0, 20'sd16, 20'sd0, 1'b1, 1'b0},	// one-vertex polygon abandoned
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},
		'{20'sd0, 20'sd0, -20'sd16, 1'b0, 1'b0},
		'{-20'sd100, 20'sd200, 20'sd5, 1'b0, 1'b0},
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},
		'{20'sd300, 20'sd0, 20'sd0, 1'b1, 1'b0},
		'{20'sd0, 20'sd0, 20'sd0, 1'b0, 1'b1},
		'{20'sd0, 20'sd0, 20'sd300, 1'b0, 1'b0}
	};

	initial begin
		stfe_pkg::in_item_t it;
		stfe_pkg::vtx_t kv;
		int plen, sent;
		scroll_reg = '0;
		eye_x = '0;
		eye_y = '0;
		eye_z = '0;
		fan_first = '0;
		fan_prev = '0;
		fan_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, registers still at reset values
		foreach (dir_rows[i]) begin
			it = '{pos_x: dir_rows[i].x, pos_y: dir_rows[i].y, pos_z: dir_rows[i].z,
				starts_polygon: dir_rows[i].start};
			if (dir_rows[i].known) begin
				kv = sky_vertex(it);
				if (kv.s !== P_MAX || kv.t !== P_MAX) begin
					$display("%0t: zero distance expected s/t %h got %h/%h", $time,
						P_MAX, kv.s, kv.t);
					fails++;
				end
			end
			send_vertex(it);
		end
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_pct = 10; rx_pct = 65;
					write_reg(stfe_pkg::CFG_SCROLL, 32'hFFFF_FFFF);
					write_reg(stfe_pkg::CFG_EYE_X, 32'(P_MAX));
					write_reg(stfe_pkg::CFG_EYE_Y, 32'(P_MAX));
					write_reg(stfe_pkg::CFG_EYE_Z, 32'(P_MAX));
				end
				1: begin
					tx_pct = 65; rx_pct = 10;
					write_reg(stfe_pkg::CFG_SCROLL, 32'h0000_7FFF);
					write_reg(stfe_pkg::CFG_EYE_X, 32'(P_MIN));
					write_reg(stfe_pkg::CFG_EYE_Y, 32'(P_MIN));
					write_reg(stfe_pkg::CFG_EYE_Z, 32'(P_MIN));
				end
				default: begin
					tx_pct = 0; rx_pct = 0;
					write_reg(stfe_pkg::CFG_SCROLL, $urandom);
					write_reg(stfe_pkg::CFG_EYE_X, $urandom);
					write_reg(stfe_pkg::CFG_EYE_Y, $urandom);
					write_reg(stfe_pkg::CFG_EYE_Z, $urandom);
				end
			endcase
			cfg_we <= 1'b0;
			sent = 0;
			while (sent < 50) begin
				plen = $urandom_range(1, 8);
				for (int k = 0; k < plen; k++) begin
					it.pos_x = pick_coord(eye_x);
					it.pos_y = pick_coord(eye_y);
					it.pos_z = pick_coord(eye_z);
					if ($urandom_range(19) == 0)
						{it.pos_x, it.pos_y, it.pos_z} = {eye_x, eye_y, eye_z};
					// a missing start mark now and then, a stray one inside rarely
					it.starts_polygon = (k == 0) ? ($urandom_range(9) != 0)
						: ($urandom_range(29) == 0);
					send_vertex(it);
					sent++;
				end
				if (ph == 1 && sent > 20 && sent <= 28) begin
					// hold the sender until every triangle is out
					in_valid <= 1'b0;
					@(posedge clk);
					while (tri_q.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
